FILE: hdl/tlik_pkg.sv
`default_nettype none
package tlik_pkg;

  // Target coordinates, signed Q11.4
  localparam int COORD_WIDTH = 16;
  // Link lengths, unsigned Q11.4
  localparam int LINK_W      = 15;
  localparam int CFG_W       = LINK_W;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_LINK1 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINK2 = 1'd1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAR  = 2'd1;
  localparam logic [1:0] ST_NEAR = 2'd2;

  localparam int SHOULDER_W = 16;
  localparam int ELBOW_W    = 15;
  localparam logic [SHOULDER_W-1:0] SHOULDER_MAX = 16'd36000;
  localparam logic [SHOULDER_W-1:0] ELBOW_MAX    = 16'd18000;

  // Square root: radicand and root
  localparam int RAD_W       = 64;
  localparam int ROOT_W      = RAD_W / 2;
  localparam int ISQRT_STEPS = RAD_W / 2;

  // Vectoring CORDIC: vector width, normalized magnitude width, angle width
  localparam int CORD_W        = 44;
  localparam int NORM_W        = 40;
  localparam int NORM_STEPS    = 6;
  localparam int CORDIC_STEPS  = 22;
  localparam int CORDIC_LAT    = 1 + NORM_STEPS + CORDIC_STEPS;
  localparam int ANG_W         = 27;
  // Angle unit is 1/25600 degree
  localparam logic signed [ANG_W-1:0] DEG90 = 27'sd2304000;
  localparam int ANG_FRAC      = 8;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] target_x;
    logic signed [COORD_WIDTH-1:0] target_y;
  } in_t;

  typedef struct packed {
    logic [SHOULDER_W-1:0] shoulder_angle;
    logic [ELBOW_W-1:0]    elbow_angle;
    logic [1:0]            status;
  } out_t;

  function automatic logic signed [ANG_W-1:0] atan_step(input int i);
    logic signed [ANG_W-1:0] a;
    unique case (i)
      0:  a = 27'sd1152000;
      1:  a = 27'sd680065;
      2:  a = 27'sd359328;
      3:  a = 27'sd182400;
      4:  a = 27'sd91554;
      5:  a = 27'sd45822;
      6:  a = 27'sd22916;
      7:  a = 27'sd11459;
      8:  a = 27'sd5730;
      9:  a = 27'sd2865;
      10: a = 27'sd1432;
      11: a = 27'sd716;
      12: a = 27'sd358;
      13: a = 27'sd179;
      14: a = 27'sd90;
      15: a = 27'sd45;
      16: a = 27'sd22;
      17: a = 27'sd11;
      18: a = 27'sd6;
      19: a = 27'sd3;
      20: a = 27'sd1;
      21: a = 27'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/two_link_inverse_kinematics_unit.sv
`default_nettype none
// Two-link planar arm inverse kinematics. Issue a target point with start; a
// transaction is taken in every cycle (busy stays low) and its result appears
// on result_o for exactly one cycle, marked by done_o, in issue order. The
// receiver cannot stall, so catch done_o when it comes. Each transaction runs
// through the 32-stage square root followed by the 29-stage CORDIC. Angles
// are in hundredths of a degree and read zero unless status is ok. Write the
// link lengths only while no transaction is in flight.
module two_link_inverse_kinematics_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  tlik_pkg::in_t                    target_i,
  output logic                             done_o,
  output tlik_pkg::out_t                   result_o,
  input  logic                             cfg_we_i,
  input  logic [tlik_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tlik_pkg::CFG_W-1:0]       cfg_data_i
);
  import tlik_pkg::*;

  localparam int CW       = COORD_WIDTH;
  localparam int SQ_W     = 2 * CW;
  localparam int LSQ_W    = 2 * LINK_W;
  localparam int SUMSQ_W  = 2 * (LINK_W + 1);
  localparam int CMP_W    = (SQ_W > SUMSQ_W) ? SQ_W : SUMSQ_W;
  localparam int D_W      = 32;
  localparam int P_W      = D_W + 3;
  localparam int QR_W     = LSQ_W + 1;
  localparam int Z_W      = ANG_W + 1;
  localparam int FRONT    = 7;
  localparam int TOTAL    = FRONT + ISQRT_STEPS + CORDIC_LAT + 2;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [CORD_W-1:0] pb;
    logic signed [CORD_W-1:0] pa;
    logic signed [CORD_W-1:0] gx;
    logic signed [CORD_W-1:0] gy;
  } side_t;

  logic [LINK_W-1:0] link1_q;
  logic [LINK_W-1:0] link2_q;
  logic [TOTAL-1:0]  vld_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link1_q <= LINK_W'(4096);
      link2_q <= LINK_W'(4096);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LINK1: link1_q <= cfg_data_i;
        REG_LINK2: link2_q <= cfg_data_i;
        default:   link2_q <= link2_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[TOTAL-2:0], start & ~busy};
    end
  end

  // Stage 1: capture the transaction
  logic signed [CW-1:0] x1_q, y1_q;
  always_ff @(posedge clk_i) begin
    x1_q <= target_i.target_x;
    y1_q <= target_i.target_y;
  end

  // Stage 2: squares
  logic [CW-1:0]          ax1, ay1;
  logic [LINK_W:0]        lsum;
  logic [LINK_W-1:0]      ldiff;
  logic [SQ_W-1:0]        axx2_q, ayy2_q;
  logic [LSQ_W-1:0]       l1sq2_q, l2sq2_q, l12_2_q, dsq2_q;
  logic [SUMSQ_W-1:0]     ssq2_q;
  logic signed [CW-1:0]   x2_q;
  logic [CW-1:0]          ay2_q;

  assign ax1   = x1_q[CW-1] ? CW'(-x1_q) : CW'(x1_q);
  assign ay1   = y1_q[CW-1] ? CW'(-y1_q) : CW'(y1_q);
  assign lsum  = (LINK_W+1)'(link1_q) + (LINK_W+1)'(link2_q);
  assign ldiff = (link1_q > link2_q) ? link1_q - link2_q : link2_q - link1_q;

  always_ff @(posedge clk_i) begin
    axx2_q  <= SQ_W'(ax1) * SQ_W'(ax1);
    ayy2_q  <= SQ_W'(ay1) * SQ_W'(ay1);
    l1sq2_q <= LSQ_W'(link1_q) * LSQ_W'(link1_q);
    l2sq2_q <= LSQ_W'(link2_q) * LSQ_W'(link2_q);
    l12_2_q <= LSQ_W'(link1_q) * LSQ_W'(link2_q);
    dsq2_q  <= LSQ_W'(ldiff) * LSQ_W'(ldiff);
    ssq2_q  <= SUMSQ_W'(lsum) * SUMSQ_W'(lsum);
    x2_q    <= x1_q;
    ay2_q   <= ay1;
  end

  // Stage 3: squared distance
  logic [SQ_W-1:0]      d2_3_q;
  logic [LSQ_W-1:0]     l1sq3_q, l2sq3_q, l12_3_q, dsq3_q;
  logic [SUMSQ_W-1:0]   ssq3_q;
  logic signed [CW-1:0] x3_q;
  logic [CW-1:0]        ay3_q;

  always_ff @(posedge clk_i) begin
    d2_3_q  <= axx2_q + ayy2_q;
    l1sq3_q <= l1sq2_q;
    l2sq3_q <= l2sq2_q;
    l12_3_q <= l12_2_q;
    dsq3_q  <= dsq2_q;
    ssq3_q  <= ssq2_q;
    x3_q    <= x2_q;
    ay3_q   <= ay2_q;
  end

  // Stage 4: reach check and cosine-law numerators
  logic [D_W-1:0]        d32_3;
  logic [1:0]            st4_d;
  logic [1:0]            st4_q;
  logic signed [P_W-1:0] pb4_q, pa4_q;
  logic [QR_W-1:0]       qr4_q;
  logic [LSQ_W-1:0]      l1sq4_q;
  logic [D_W-1:0]        d32_4_q;
  logic signed [CW-1:0]  x4_q;
  logic [CW-1:0]         ay4_q;

  assign d32_3 = D_W'(d2_3_q);

  always_comb begin
    if (CMP_W'(d2_3_q) > CMP_W'(ssq3_q)) begin
      st4_d = ST_FAR;
    end else if (d2_3_q == '0 || CMP_W'(d2_3_q) < CMP_W'(dsq3_q)) begin
      st4_d = ST_NEAR;
    end else begin
      st4_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    st4_q   <= st4_d;
    pb4_q   <= P_W'(d32_3) - P_W'(l1sq3_q) - P_W'(l2sq3_q);
    pa4_q   <= P_W'(d32_3) + P_W'(l1sq3_q) - P_W'(l2sq3_q);
    qr4_q   <= {l12_3_q, 1'b0};
    l1sq4_q <= l1sq3_q;
    d32_4_q <= d32_3;
    x4_q    <= x3_q;
    ay4_q   <= ay3_q;
  end

  // Stage 5: magnitudes
  logic [P_W-1:0]        apb4, apa4;
  logic [D_W-1:0]        apb5_q, apa5_q;
  logic                  biga5_q;
  logic [1:0]            st5_q;
  logic signed [P_W-1:0] pb5_q, pa5_q;
  logic [QR_W-1:0]       qr5_q;
  logic [LSQ_W-1:0]      l1sq5_q;
  logic [D_W-1:0]        d32_5_q;
  logic signed [CW-1:0]  x5_q;
  logic [CW-1:0]         ay5_q;

  assign apb4 = pb4_q[P_W-1] ? P_W'(-pb4_q) : P_W'(pb4_q);
  assign apa4 = pa4_q[P_W-1] ? P_W'(-pa4_q) : P_W'(pa4_q);

  always_ff @(posedge clk_i) begin
    apb5_q  <= apb4[D_W-1:0];
    apa5_q  <= apa4[D_W-1:0];
    biga5_q <= (apa4[P_W-1:D_W] != '0);
    st5_q   <= st4_q;
    pb5_q   <= pb4_q;
    pa5_q   <= pa4_q;
    qr5_q   <= qr4_q;
    l1sq5_q <= l1sq4_q;
    d32_5_q <= d32_4_q;
    x5_q    <= x4_q;
    ay5_q   <= ay4_q;
  end

  // Stage 6: squares for the arc cosine radicands
  logic [RAD_W-1:0]      p2b6_q, p2a6_q, q2b6_q, q2a6_q;
  logic                  biga6_q;
  logic [1:0]            st6_q;
  logic signed [P_W-1:0] pb6_q, pa6_q;
  logic signed [CW-1:0]  x6_q;
  logic [CW-1:0]         ay6_q;

  always_ff @(posedge clk_i) begin
    p2b6_q  <= RAD_W'(apb5_q) * RAD_W'(apb5_q);
    p2a6_q  <= RAD_W'(apa5_q) * RAD_W'(apa5_q);
    q2b6_q  <= RAD_W'(qr5_q) * RAD_W'(qr5_q);
    q2a6_q  <= RAD_W'({l1sq5_q, 2'b00}) * RAD_W'(d32_5_q);
    biga6_q <= biga5_q;
    st6_q   <= st5_q;
    pb6_q   <= pb5_q;
    pa6_q   <= pa5_q;
    x6_q    <= x5_q;
    ay6_q   <= ay5_q;
  end

  // Stage 7: radicands, clamp at zero
  logic [RAD_W-1:0] rb7_q, ra7_q;
  side_t            side7_q;

  always_ff @(posedge clk_i) begin
    rb7_q <= (q2b6_q > p2b6_q) ? q2b6_q - p2b6_q : '0;
    ra7_q <= (!biga6_q && q2a6_q > p2a6_q) ? q2a6_q - p2a6_q : '0;
    side7_q.status <= st6_q;
    side7_q.pb     <= CORD_W'(pb6_q);
    side7_q.pa     <= CORD_W'(pa6_q);
    side7_q.gx     <= CORD_W'(x6_q);
    side7_q.gy     <= CORD_W'(ay6_q);
  end

  logic [ROOT_W-1:0] sb, sa;

  tlik_isqrt u_isqrt_b (
    .clk_i  (clk_i),
    .rad_i  (rb7_q),
    .root_o (sb)
  );

  tlik_isqrt u_isqrt_a (
    .clk_i  (clk_i),
    .rad_i  (ra7_q),
    .root_o (sa)
  );

  side_t side_q [ISQRT_STEPS];
  always_ff @(posedge clk_i) begin
    side_q[0] <= side7_q;
    for (int k = 1; k < ISQRT_STEPS; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  side_t                   sd;
  logic signed [ANG_W-1:0] zb, za, zg;
  assign sd = side_q[ISQRT_STEPS-1];

  tlik_cordic u_cordic_b (
    .clk_i (clk_i),
    .x_i   (sd.pb),
    .y_i   (CORD_W'(sb)),
    .z_o   (zb)
  );

  tlik_cordic u_cordic_a (
    .clk_i (clk_i),
    .x_i   (sd.pa),
    .y_i   (CORD_W'(sa)),
    .z_o   (za)
  );

  tlik_cordic u_cordic_g (
    .clk_i (clk_i),
    .x_i   (sd.gx),
    .y_i   (sd.gy),
    .z_o   (zg)
  );

  logic [1:0] stc_q [CORDIC_LAT];
  always_ff @(posedge clk_i) begin
    stc_q[0] <= sd.status;
    for (int k = 1; k < CORDIC_LAT; k++) begin
      stc_q[k] <= stc_q[k-1];
    end
  end

  // Sum the shoulder angle
  logic signed [Z_W-1:0] zb_q, zs_q;
  logic [1:0]            stz_q;
  always_ff @(posedge clk_i) begin
    zb_q  <= Z_W'(zb);
    zs_q  <= Z_W'(za) + Z_W'(zg);
    stz_q <= stc_q[CORDIC_LAT-1];
  end

  // Round half up to hundredths, clamp below at zero and above at the limit
  function automatic logic [SHOULDER_W-1:0] to_hund(
    input logic signed [Z_W-1:0] z,
    input logic [SHOULDER_W-1:0] lim
  );
    logic [Z_W-1:0] r;
    r = (Z_W'(z) + Z_W'(1 << (ANG_FRAC - 1))) >> ANG_FRAC;
    if (z[Z_W-1]) begin
      return '0;
    end else if (r > Z_W'(lim)) begin
      return lim;
    end else begin
      return r[SHOULDER_W-1:0];
    end
  endfunction

  logic [SHOULDER_W-1:0] elbow_full;
  assign elbow_full = to_hund(zb_q, ELBOW_MAX);

  always_ff @(posedge clk_i) begin
    result_o.status <= stz_q;
    if (stz_q == ST_OK) begin
      result_o.shoulder_angle <= to_hund(zs_q, SHOULDER_MAX);
      result_o.elbow_angle    <= elbow_full[ELBOW_W-1:0];
    end else begin
      result_o.shoulder_angle <= '0;
      result_o.elbow_angle    <= '0;
    end
  end

  assign done_o = vld_q[TOTAL-1];

endmodule
`default_nettype wire

FILE: hdl/tlik_isqrt.sv
`default_nettype none
module tlik_isqrt (
  input  logic                        clk_i,
  input  logic [tlik_pkg::RAD_W-1:0]  rad_i,
  output logic [tlik_pkg::ROOT_W-1:0] root_o
);
  import tlik_pkg::*;

  // One restoring step per stage, two radicand bits at a time
  logic [RAD_W-1:0] n_q [ISQRT_STEPS-1];
  logic [RAD_W-1:0] r_q [ISQRT_STEPS];

  for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_step
    localparam logic [RAD_W-1:0] Bit = RAD_W'(1) << (RAD_W - 2 - 2 * k);
    logic [RAD_W-1:0] n_in;
    logic [RAD_W-1:0] r_in;
    logic [RAD_W:0]   trial;
    logic             take;

    if (k == 0) begin : g_first
      assign n_in = rad_i;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = n_q[k-1];
      assign r_in = r_q[k-1];
    end

    assign trial = (RAD_W+1)'(r_in) + (RAD_W+1)'(Bit);
    assign take  = (RAD_W+1)'(n_in) >= trial;

    always_ff @(posedge clk_i) begin
      r_q[k] <= take ? (r_in >> 1) + Bit : r_in >> 1;
    end

    if (k < ISQRT_STEPS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        n_q[k] <= take ? n_in - trial[RAD_W-1:0] : n_in;
      end
    end
  end

  assign root_o = r_q[ISQRT_STEPS-1][ROOT_W-1:0];

endmodule
`default_nettype wire

FILE: hdl/tlik_cordic.sv
`default_nettype none
module tlik_cordic (
  input  logic                               clk_i,
  input  logic signed [tlik_pkg::CORD_W-1:0] x_i,
  input  logic signed [tlik_pkg::CORD_W-1:0] y_i,
  output logic signed [tlik_pkg::ANG_W-1:0]  z_o
);
  import tlik_pkg::*;

  // y_i is never negative; result is atan2(y_i, x_i), zero for a zero vector
  logic signed [CORD_W-1:0] x_q [CORDIC_LAT];
  logic signed [CORD_W-1:0] y_q [CORDIC_LAT];
  logic signed [ANG_W-1:0]  z_q [CORDIC_LAT];
  logic                     zero_q [CORDIC_LAT];
  logic [NORM_W-1:0]        m_q [NORM_STEPS+1];

  logic signed [CORD_W-1:0] rx;
  logic signed [CORD_W-1:0] ry;
  logic signed [ANG_W-1:0]  rz;

  // Fold the left half plane into the right one
  always_comb begin
    if (x_i[CORD_W-1]) begin
      rx = y_i;
      ry = -x_i;
      rz = DEG90;
    end else begin
      rx = x_i;
      ry = y_i;
      rz = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= rx;
    y_q[0]    <= ry;
    z_q[0]    <= rz;
    zero_q[0] <= (x_i == '0) && (y_i == '0);
    m_q[0]    <= (rx > ry) ? NORM_W'(rx) : NORM_W'(ry);
  end

  // Scale up until the larger component reaches the top bit
  for (genvar j = 1; j <= NORM_STEPS; j++) begin : g_norm
    localparam int Sh = 1 << (NORM_STEPS - j);
    logic small_m;
    assign small_m = (m_q[j-1][NORM_W-1 -: Sh] == '0);

    always_ff @(posedge clk_i) begin
      x_q[j]    <= small_m ? x_q[j-1] <<< Sh : x_q[j-1];
      y_q[j]    <= small_m ? y_q[j-1] <<< Sh : y_q[j-1];
      m_q[j]    <= small_m ? m_q[j-1] << Sh : m_q[j-1];
      z_q[j]    <= z_q[j-1];
      zero_q[j] <= zero_q[j-1];
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    localparam int J = NORM_STEPS + 1 + i;
    logic signed [CORD_W-1:0] xs;
    logic signed [CORD_W-1:0] ys;
    logic                     pos;
    assign xs  = x_q[J-1] >>> i;
    assign ys  = y_q[J-1] >>> i;
    assign pos = !y_q[J-1][CORD_W-1] && (y_q[J-1] != '0);

    always_ff @(posedge clk_i) begin
      if (pos) begin
        x_q[J] <= x_q[J-1] + ys;
        y_q[J] <= y_q[J-1] - xs;
        z_q[J] <= z_q[J-1] + atan_step(i);
      end else begin
        x_q[J] <= x_q[J-1] - ys;
        y_q[J] <= y_q[J-1] + xs;
        z_q[J] <= z_q[J-1] - atan_step(i);
      end
      zero_q[J] <= zero_q[J-1];
    end
  end

  assign z_o = zero_q[CORDIC_LAT-1] ? '0 : z_q[CORDIC_LAT-1];

endmodule
`default_nettype wire
